FILE: rtl/mme_pkg.sv
package mme_pkg;

   // Sequencer states of the exponentiation controller.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_WAIT,
      ST_NEXT,
      ST_FINISH
   } mme_state_type;

   // Which modular multiply the controller is running.
   typedef enum logic [1:0] {
      OP_REDUCE,
      OP_MULT,
      OP_SQUARE
   } mme_op_type;

   // Status of the bit-serial modular multiplier.
   typedef struct packed {
      logic busy;
      logic done;
   } mme_mul_status_type;

endpackage

FILE: rtl/mme_mulmod.sv
module mme_mulmod
   import mme_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WORD_BITS-1:0] operand_a,
   input  logic [WORD_BITS-1:0] operand_b,
   input  logic [WORD_BITS-1:0] modulus,
   output mme_mul_status_type   status,
   output logic [WORD_BITS-1:0] product
);

   localparam int CNT_BITS = $clog2(WORD_BITS);

   logic                 busy_ff,  busy_in;
   logic                 done_ff,  done_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [WORD_BITS-1:0] acc_ff,   acc_in;
   logic [WORD_BITS-1:0] a_ff,     a_in;
   logic [WORD_BITS-1:0] b_ff,     b_in;

   logic [WORD_BITS:0]   dbl;
   logic [WORD_BITS-1:0] dbl_red;
   logic [WORD_BITS:0]   sum;
   logic [WORD_BITS-1:0] step_val;

   // One multiplier bit per cycle, top bit first: double, then add a if the bit is set.
   always_comb begin
      dbl = {acc_ff, 1'b0};
      if (dbl >= {1'b0, modulus}) begin
         dbl_red = WORD_BITS'(dbl - {1'b0, modulus});
      end else begin
         dbl_red = dbl[WORD_BITS-1:0];
      end
      sum = {1'b0, dbl_red} + {1'b0, a_ff};
      if (!b_ff[WORD_BITS-1]) begin
         step_val = dbl_red;
      end else if (sum >= {1'b0, modulus}) begin
         step_val = WORD_BITS'(sum - {1'b0, modulus});
      end else begin
         step_val = sum[WORD_BITS-1:0];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      acc_in   = acc_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(WORD_BITS - 1);
         acc_in   = '0;
         a_in     = operand_a;
         b_in     = operand_b;
      end else if (busy_ff) begin
         acc_in = step_val;
         b_in   = {b_ff[WORD_BITS-2:0], 1'b0};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      acc_ff   <= acc_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

FILE: rtl/modular_exponentiation_64.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  req_base_value, req_exponent, req_modulus
// rsp       out        rsp_valid/rsp_ready  rsp_power_residue
//
// One transaction at a time. Each modular multiply runs one multiplier bit per cycle. A
// transaction needs one multiply to reduce the base, one per set exponent bit and one squaring
// per exponent bit below the top set bit. A modulus of 0 or 1 needs no multiply and gives a
// result of zero. Reset is synchronous and active high. A new request is taken while a finished
// result still waits on rsp; a stalled rsp only holds the next result in the sequencer.
module modular_exponentiation_64
   import mme_pkg::*;
#(
   parameter int WORD_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [WORD_BITS-1:0] req_base_value,
   input  logic [WORD_BITS-1:0] req_exponent,
   input  logic [WORD_BITS-1:0] req_modulus,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WORD_BITS-1:0] rsp_power_residue
);

   mme_state_type        state_ff, state_in;
   mme_op_type           op_ff,    op_in;
   logic [WORD_BITS-1:0] exp_ff,    exp_in;
   logic [WORD_BITS-1:0] sq_ff,     sq_in;
   logic [WORD_BITS-1:0] result_ff, result_in;
   logic [WORD_BITS-1:0] mod_ff,    mod_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [WORD_BITS-1:0] rsp_data_ff,  rsp_data_in;

   logic                 mm_start;
   logic [WORD_BITS-1:0] mm_a;
   logic [WORD_BITS-1:0] mm_b;
   mme_mul_status_type   mm_status;
   logic [WORD_BITS-1:0] mm_product;
   logic                 rsp_load;

   // The base is reduced by multiplying 1 by the raw base: the bit-serial multiplier then
   // performs a Horner reduction of the base, which needs no divider.
   always_comb begin
      case (op_ff)
         OP_REDUCE: begin
            mm_a = WORD_BITS'(1);
            mm_b = sq_ff;
         end
         OP_MULT: begin
            mm_a = result_ff;
            mm_b = sq_ff;
         end
         OP_SQUARE: begin
            mm_a = sq_ff;
            mm_b = sq_ff;
         end
         default: begin
            mm_a = sq_ff;
            mm_b = sq_ff;
         end
      endcase
   end

   mme_mulmod #(
      .WORD_BITS (WORD_BITS)
   ) u_mulmod (
      .clock     (clock),
      .reset     (reset),
      .start     (mm_start),
      .operand_a (mm_a),
      .operand_b (mm_b),
      .modulus   (mod_ff),
      .status    (mm_status),
      .product   (mm_product)
   );

   // Right-to-left scan: the exponent shifts down one bit after each squaring, and a set low
   // bit is cleared once its multiply is done. The scan stops as soon as no bits remain.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      exp_in       = exp_ff;
      sq_in        = sq_ff;
      result_in    = result_ff;
      mod_in       = mod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      mm_start     = 1'b0;
      rsp_load     = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               exp_in = req_exponent;
               sq_in  = req_base_value;
               mod_in = req_modulus;
               op_in  = OP_REDUCE;
               // A modulus of zero or one has no nonzero residue.
               if (req_modulus[WORD_BITS-1:1] == '0) begin
                  result_in = '0;
                  state_in  = ST_FINISH;
               end else begin
                  result_in = WORD_BITS'(1);
                  state_in  = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            mm_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mm_status.done) begin
               state_in = ST_NEXT;
               case (op_ff)
                  OP_MULT: begin
                     result_in = mm_product;
                     exp_in    = {exp_ff[WORD_BITS-1:1], 1'b0};
                  end
                  OP_SQUARE: begin
                     sq_in  = mm_product;
                     exp_in = {1'b0, exp_ff[WORD_BITS-1:1]};
                  end
                  default: begin
                     sq_in = mm_product;
                  end
               endcase
            end
         end
         ST_NEXT: begin
            if (exp_ff == '0) begin
               state_in = ST_FINISH;
            end else if (exp_ff[0]) begin
               op_in    = OP_MULT;
               state_in = ST_ISSUE;
            end else begin
               op_in    = OP_SQUARE;
               state_in = ST_ISSUE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      exp_ff      <= exp_in;
      sq_ff       <= sq_in;
      result_ff   <= result_in;
      mod_ff      <= mod_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_power_residue = rsp_data_ff;

   // A multiply is only started when the multiplier is free.
   a_start_free: assert property (@(posedge clock) disable iff (reset)
      mm_start |-> !mm_status.busy)
      else $error("multiply started while the multiplier is busy");

   // A new transaction is never taken while a multiply is in flight.
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!mm_status.busy && !mm_status.done))
      else $error("request accepted during a multiply");

   // A multiply completion is only seen while the sequencer waits for it.
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      mm_status.done |-> (state_ff == ST_WAIT))
      else $error("multiply completed outside the wait state");

   // Every delivered residue lies below the modulus, or is zero for a trivial modulus.
   a_residue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> ((result_ff < mod_ff) || (result_ff == '0)))
      else $error("residue not reduced by the modulus");

endmodule

FILE: bench/tb_modular_exponentiation_64.sv
module tb_modular_exponentiation_64;

   localparam int WORD_BITS = 64;
   localparam int RANDOM_ITEMS = 100;
   // Longer than the slowest transaction, so this many cycles with no handshake at all means a hang.
   localparam int STALL_LIMIT = 50000;
   // Cycles to keep watching the result channel after the last expected residue.
   localparam int DRAIN_CYCLES = 200;
   localparam int REPORT_LIMIT = 10;

   localparam logic [WORD_BITS-1:0] ALL_ONES = '1;
   localparam logic [WORD_BITS-1:0] TOP_BIT = 64'h8000_0000_0000_0000;

   // One row of the directed table. When "known" is set, the residue column is the
   // answer written in by hand. Otherwise the predictor computes it.
   typedef struct packed {
      logic [WORD_BITS-1:0] base_value;
      logic [WORD_BITS-1:0] exponent;
      logic [WORD_BITS-1:0] modulus;
      logic                 known;
      logic [WORD_BITS-1:0] residue;
   } operand_row_type;

   localparam int DIRECTED_ROWS = 17;
   localparam operand_row_type DIRECTED [DIRECTED_ROWS] = '{
      // An exponent of zero gives one whenever the modulus is above one.
      '{64'd0, 64'd0, ALL_ONES, 1'b1, 64'd1},
      '{64'd7, 64'd0, 64'd2, 1'b1, 64'd1},
      // A modulus of one gives zero, whatever the exponent is.
      '{ALL_ONES, ALL_ONES, 64'd1, 1'b1, 64'd0},
      '{64'd0, 64'd0, 64'd1, 1'b1, 64'd0},
      // Extremes of the base, read straight off.
      '{ALL_ONES, 64'd1, ALL_ONES, 1'b1, 64'd0},
      '{ALL_ONES, 64'd1, ALL_ONES - 64'd1, 1'b1, 64'd1},
      '{64'd0, ALL_ONES, ALL_ONES, 1'b1, 64'd0},
      '{64'd1, ALL_ONES, TOP_BIT, 1'b1, 64'd1},
      '{ALL_ONES, 64'd2, 64'd2, 1'b1, 64'd1},
      '{64'd2, 64'd10, 64'd1000, 1'b1, 64'd24},
      // The rest go through the predictor: odd and even moduli, and a base above the modulus.
      '{64'd3, ALL_ONES, ALL_ONES, 1'b0, 64'd0},
      '{ALL_ONES - 64'd1, ALL_ONES, TOP_BIT, 1'b0, 64'd0},
      '{64'h0123_4567_89AB_CDEF, TOP_BIT, 64'hFFFF_FFFF_FFFF_FFC5, 1'b0, 64'd0},
      '{TOP_BIT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0, 64'd0},
      '{64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'd0},
      '{ALL_ONES, ALL_ONES, ALL_ONES - 64'd1, 1'b0, 64'd0},
      '{ALL_ONES, 64'd3, 64'd10, 1'b0, 64'd0}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [WORD_BITS-1:0] req_base_value = '0;
   logic [WORD_BITS-1:0] req_exponent = '0;
   logic [WORD_BITS-1:0] req_modulus = '1;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [WORD_BITS-1:0] rsp_power_residue;

   // Residues still owed by the block, oldest first.
   logic [WORD_BITS-1:0] owed_residues [$];
   int                   mismatch_count = 0;
   int                   quiet_cycles = 0;
   // While this is set, neither side inserts any idle cycles.
   bit                   steady = 1'b0;

   modular_exponentiation_64 #(
      .WORD_BITS(WORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_base_value(req_base_value),
      .req_exponent(req_exponent),
      .req_modulus(req_modulus),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_power_residue(rsp_power_residue)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Power residue by right-to-left square-and-multiply. Each product is formed at full
   // double width and reduced with the modulus directly, which is exact for any modulus.
   function automatic logic [WORD_BITS-1:0] power_residue(input logic [WORD_BITS-1:0] base_in,
                                                          input logic [WORD_BITS-1:0] expo,
                                                          input logic [WORD_BITS-1:0] modulus);
      logic [2*WORD_BITS-1:0] wide_mod;
      logic [2*WORD_BITS-1:0] product;
      logic [WORD_BITS-1:0]   running;
      logic [WORD_BITS-1:0]   square;
      if (modulus <= 1) begin
         return '0;
      end
      wide_mod = {{WORD_BITS{1'b0}}, modulus};
      running = WORD_BITS'(1);
      square = base_in % modulus;
      for (int bit_pos = 0; bit_pos < WORD_BITS; bit_pos++) begin
         if (expo[bit_pos]) begin
            product = {{WORD_BITS{1'b0}}, running} * {{WORD_BITS{1'b0}}, square};
            running = WORD_BITS'(product % wide_mod);
         end
         product = {{WORD_BITS{1'b0}}, square} * {{WORD_BITS{1'b0}}, square};
         square = WORD_BITS'(product % wide_mod);
      end
      return running;
   endfunction

   function automatic logic [WORD_BITS-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   // Presents one transaction on the request channel and records the residue it must
   // produce once the block has accepted it. Idle cycles come before valid is raised,
   // never while a transaction is pending.
   task automatic send_operands(input logic [WORD_BITS-1:0] base_in,
                                input logic [WORD_BITS-1:0] expo,
                                input logic [WORD_BITS-1:0] modulus,
                                input logic                 known,
                                input logic [WORD_BITS-1:0] known_residue);
      logic [WORD_BITS-1:0] owed;
      @(negedge clock);
      while (!steady && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_base_value <= base_in;
      req_exponent <= expo;
      req_modulus <= modulus;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      owed = known ? known_residue : power_residue(base_in, expo, modulus);
      owed_residues = {owed_residues, owed};
   endtask

   // Holds the request channel idle until every owed residue has come back.
   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_residues.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // The receiver stalls at random, except during the steady stretch.
   always @(negedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 17);
   end

   // Every accepted result is checked against the oldest owed residue. A result that
   // arrives with nothing owed is a failure of its own.
   always @(posedge clock) begin
      logic [WORD_BITS-1:0] wanted;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_residues.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected result transaction: power_residue %h", rsp_power_residue);
            end
         end else begin
            wanted = owed_residues.pop_front();
            if (rsp_power_residue !== wanted) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("power_residue mismatch: expected %h, got %h",
                           wanted, rsp_power_residue);
               end
            end
         end
      end
   end

   // Watchdog: a run in which no transaction moves on either channel for too long is hung.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("modular_exponentiation_64 test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [WORD_BITS-1:0] base_in;
      logic [WORD_BITS-1:0] expo;
      logic [WORD_BITS-1:0] modulus;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table first: special cases and field extremes.
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         send_operands(DIRECTED[row].base_value, DIRECTED[row].exponent,
                       DIRECTED[row].modulus, DIRECTED[row].known, DIRECTED[row].residue);
      end
      hold_until_drained();

      // Random part. Moduli lean toward the awkward ones (one, all ones, small, even),
      // and some exponents are small so that short and long transactions interleave.
      for (int item = 0; item < RANDOM_ITEMS; item++) begin
         steady = (item >= 60 && item < 80);
         if (item == 40) begin
            hold_until_drained();
         end
         case ($urandom_range(9))
            0: modulus = 64'd1;
            1: modulus = ALL_ONES;
            2: modulus = 64'($urandom_range(1000, 2));
            3: modulus = random_word() & ~64'd1;
            4: modulus = random_word() | TOP_BIT;
            default: modulus = random_word();
         endcase
         if (modulus == 0) begin
            modulus = 64'd2;
         end
         case ($urandom_range(7))
            0: base_in = '0;
            1: base_in = ALL_ONES;
            2: base_in = 64'($urandom_range(20));
            3: base_in = modulus - 64'd1;
            default: base_in = random_word();
         endcase
         case ($urandom_range(9))
            0: expo = '0;
            1: expo = 64'd1;
            2: expo = ALL_ONES;
            3, 4: expo = 64'($urandom_range(200));
            5: expo = 64'd1 << $urandom_range(WORD_BITS - 1);
            default: expo = random_word();
         endcase
         send_operands(base_in, expo, modulus, 1'b0, '0);
      end
      steady = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_residues.size() != 0) begin
         @(posedge clock);
      end
      // Keep watching a while longer, so that a stray extra result is caught.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("modular_exponentiation_64 test passed");
      end else begin
         $display("modular_exponentiation_64 test failed");
      end
      $finish;
   end

endmodule
